@@ hw/rtl/cqr_pkg.sv @@
// Shared types, codes and helpers for the circular queue with readout.
// Used by cqr_ctrl, cqr_dp and circular_queue_with_readout; no dependencies.
package cqr_pkg;

	localparam int DEPTH = 64;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	localparam logic [1:0] ACT_INSERT  = 2'd0;
	localparam logic [1:0] ACT_SERVE   = 2'd1;
	localparam logic [1:0] ACT_READOUT = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic       push;        // write value at tail
		logic       pop;         // read head word, advance head
		logic       walk_start;  // read head word, load walk pointer and count
		logic       walk_step;   // read next word of the walk
		logic       emit;        // present a result next cycle
		logic [1:0] status;
		logic       last;
		logic       use_word;    // result carries the word read this cycle
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic one;        // exactly one word held
		logic walk_last;  // the walk has one word left to emit
	} sts_t;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] idx);
		if (idx == PTR_W'(DEPTH - 1))
			return '0;
		else
			return idx + PTR_W'(1);
	endfunction

endpackage

@@ hw/rtl/cqr_ctrl.sv @@
// Controller for the circular queue: idle/walk state machine that decodes
// each item into datapath commands. Depends on cqr_pkg.
module cqr_ctrl import cqr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_WALK = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_INSERT: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							if (sts.full) begin
								cmd.status = ST_FULL;
							end else begin
								cmd.push = 1'b1;
								cmd.status = ST_OK;
							end
						end
						ACT_SERVE: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							if (sts.empty) begin
								cmd.status = ST_EMPTY;
							end else begin
								cmd.pop = 1'b1;
								cmd.status = ST_OK;
								cmd.use_word = 1'b1;
							end
						end
						ACT_READOUT: begin
							cmd.emit = 1'b1;
							if (sts.empty) begin
								cmd.status = ST_EMPTY;
								cmd.last = 1'b1;
							end else begin
								cmd.walk_start = 1'b1;
								cmd.status = ST_OK;
								cmd.use_word = 1'b1;
								cmd.last = sts.one;
								if (!sts.one)
									state_d = S_WALK;
							end
						end
						default: begin
							// undefined action: drop the item
						end
					endcase
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				cmd.emit = 1'b1;
				cmd.status = ST_OK;
				cmd.use_word = 1'b1;
				cmd.last = sts.walk_last;
				if (sts.walk_last)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q == S_WALK);

endmodule

@@ hw/rtl/cqr_dp.sv @@
// Datapath for the circular queue: word store, head/tail pointers, occupancy,
// readout walk counter and result registers. Depends on cqr_pkg.
module cqr_dp import cqr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic signed [WORD_W-1:0] value,
	output sts_t                     sts,
	output logic                     strobe,
	output logic [1:0]               status,
	output logic signed [WORD_W-1:0] data,
	output logic                     last
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  walk_ptr_q;
	logic [CNT_W-1:0]  rem_q;
	logic [WORD_W-1:0] rd_q;
	logic              strobe_q;
	logic [1:0]        status_q;
	logic              last_q;
	logic              use_q;
	logic [PTR_W-1:0]  rd_addr;

	assign rd_addr = cmd.walk_step ? walk_ptr_q : head_q;

	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[tail_q] <= value;
		if (cmd.pop || cmd.walk_start || cmd.walk_step)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.push) begin
				tail_q  <= next_slot(tail_q);
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				head_q  <= next_slot(head_q);
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Walk pointer and remaining count need no reset: loaded at walk start.
	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			walk_ptr_q <= next_slot(head_q);
			rem_q      <= count_q - CNT_W'(1);
		end else if (cmd.walk_step) begin
			walk_ptr_q <= next_slot(walk_ptr_q);
			rem_q      <= rem_q - CNT_W'(1);
		end
		if (cmd.emit) begin
			status_q <= cmd.status;
			last_q   <= cmd.last;
			use_q    <= cmd.use_word;
		end
	end

	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == CNT_W'(DEPTH));
	assign sts.one       = (count_q == CNT_W'(1));
	assign sts.walk_last = (rem_q == CNT_W'(1));

	assign strobe = strobe_q;
	assign status = status_q;
	assign last   = last_q;
	assign data   = use_q ? rd_q : '0;

endmodule

@@ hw/rtl/circular_queue_with_readout.sv @@
// Top level of the circular queue with readout: controller plus datapath.
// Depends on cqr_pkg, cqr_ctrl and cqr_dp.
//
// Usage: present action and value with start high; the item is taken at a
// clock edge where start is high and busy is low. Action insert stores value
// at the tail (status full and the value dropped when all DEPTH slots are
// held); serve returns the oldest word (status empty when nothing is held);
// readout returns every held word from oldest to newest, last set on the
// final one, or one empty result. Action code 3 is dropped with no result.
// Every result appears on status, data and last for exactly one cycle with
// strobe high; the receiver has no way to stall and must take it then.
// The result of an item shows in the cycle after it is taken.
// Insert and serve items can follow each other back to back; a readout
// of N held words emits one word per cycle from a single-port store read and
// holds busy high after it is taken until its final word is read.
// Reset (arst_n low) empties the queue and clears head, tail and the
// controller; store contents are not cleared.
module circular_queue_with_readout import cqr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               action,
	input  logic signed [WORD_W-1:0] value,
	output logic                     strobe,
	output logic [1:0]               status,
	output logic signed [WORD_W-1:0] data,
	output logic                     last
);

	cmd_t cmd;
	sts_t sts;

	cqr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	cqr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (value),
		.sts    (sts),
		.strobe (strobe),
		.status (status),
		.data   (data),
		.last   (last)
	);

	// A walk in progress emits a word every cycle.
	a_walk_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> strobe)
		else $error("readout walk skipped a cycle");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status != ST_OK) |-> (last && data == '0))
		else $error("error result not final or carries data");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.full && sts.empty))
		else $error("queue both full and empty");

	a_no_push_walk: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(cmd.push || cmd.pop))
		else $error("queue changed during readout walk");

endmodule
